// ----- design/i2cbs_pkg.sv -----
// Shared types and constants of the I2C master bit sequencer.
package i2cbs_pkg;

	// Command codes carried by the cmd field.
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_SEND  = 3'd3;
	localparam logic [2:0] CMD_WACK  = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

	// Register reset values.
	localparam logic [15:0] HALF_PERIOD_RST = 16'd10;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;

	// Bits in one byte.
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// One input item.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_data;
		logic       send_ack;
		logic       sda_in;
	} i2cbs_item_t;

	// One result item.
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_ok;
		logic       timed_out;
	} i2cbs_res_t;

endpackage

// ----- design/i2cbs_cfg.sv -----
// Configuration registers with saturation to the counter range.
module i2cbs_cfg
	import i2cbs_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [1:0]             wr_index,
	input  logic [15:0]            wr_data,
	output logic [COUNT_WIDTH-1:0] hold,
	output logic [COUNT_WIDTH-1:0] limit
);

	logic [15:0] half_q;
	logic [15:0] tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RST;
			tmo_q  <= ACK_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_HALF_PERIOD: half_q <= wr_data;
				CFG_ACK_TIMEOUT: tmo_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Values above the counter range clamp to the counter maximum.
	if (COUNT_WIDTH >= 16) begin : g_wide
		assign hold  = COUNT_WIDTH'(half_q);
		assign limit = COUNT_WIDTH'(tmo_q);
	end else begin : g_narrow
		assign hold  = (|half_q[15:COUNT_WIDTH]) ? '1 : half_q[COUNT_WIDTH-1:0];
		assign limit = (|tmo_q[15:COUNT_WIDTH]) ? '1 : tmo_q[COUNT_WIDTH-1:0];
	end

endmodule

// ----- design/i2cbs_seq.sv -----
// Line sequencer state and the per-tick next-state logic.
module i2cbs_seq
	import i2cbs_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  i2cbs_item_t            item,
	input  logic [COUNT_WIDTH-1:0] hold,
	input  logic [COUNT_WIDTH-1:0] limit,
	output i2cbs_res_t             res
);

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST0, PH_ST1, PH_ST2,
		PH_SP0, PH_SP1, PH_SP2,
		PH_TX0, PH_TX1, PH_TX2,
		PH_WA0, PH_WA1,
		PH_RD0, PH_RD1, PH_RD2,
		PH_AK0, PH_AK1, PH_AK2, PH_AK3, PH_AK4
	} phase_t;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	phase_t                 phase_q, phase_n;
	logic [COUNT_WIDTH-1:0] tick_q, tick_n;
	logic [3:0]             bit_q, bit_n;
	logic [7:0]             shift_q, shift_n;
	logic [COUNT_WIDTH-1:0] wait_q, wait_n;
	logic                   scl_q, scl_n;
	logic                   sda_q, sda_n;
	logic                   en_q, en_n;
	logic [1:0]             flags_q, flags_n;
	logic                   choice_q, choice_n;
	logic [7:0]             rdata_q, rdata_n;
	logic                   done_n;

	always_comb begin
		logic [COUNT_WIDTH-1:0] tick_inc;
		logic [3:0]             bit_inc;
		logic [7:0]             rd_shift;
		phase_n  = phase_q;
		tick_n   = tick_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		wait_n   = wait_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		en_n     = en_q;
		flags_n  = flags_q;
		choice_n = choice_q;
		rdata_n  = rdata_q;
		done_n   = 1'b0;
		tick_inc = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
		bit_inc  = 4'(bit_q + 4'd1);
		rd_shift = {shift_q[6:0], item.sda_in};

		if (phase_q == PH_IDLE) begin
			unique case (item.cmd)
				CMD_START: begin
					en_n = 1'b1; sda_n = 1'b1; scl_n = 1'b1;
					phase_n = PH_ST0; tick_n = '0;
				end
				CMD_STOP: begin
					en_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0;
					phase_n = PH_SP0; tick_n = '0;
				end
				CMD_SEND: begin
					bit_n = '0;
					scl_n = 1'b0; sda_n = item.tx_data[7];
					shift_n = {item.tx_data[6:0], 1'b0};
					en_n = 1'b1; phase_n = PH_TX0; tick_n = '0;
				end
				CMD_WACK: begin
					flags_n = 2'b00;
					en_n = 1'b0; sda_n = 1'b1; scl_n = 1'b1;
					wait_n = '0; phase_n = PH_WA0; tick_n = '0;
				end
				CMD_READ: begin
					choice_n = item.send_ack;
					shift_n = '0; bit_n = '0; en_n = 1'b0;
					phase_n = PH_RD0; tick_n = '0;
				end
				default: ;
			endcase
		end else if (phase_q == PH_WA1) begin
			// Polling for the acknowledge: one poll per tick, no hold.
			if (!item.sda_in) begin
				scl_n = 1'b0; flags_n = 2'b01;
				phase_n = PH_IDLE; tick_n = '0; done_n = 1'b1;
			end else if (wait_q >= limit) begin
				flags_n = 2'b10;
				en_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0;
				phase_n = PH_SP0; tick_n = '0;
			end else begin
				wait_n = wait_q + 1'b1;
			end
		end else begin
			tick_n = tick_inc;
			if (tick_inc >= hold) begin
				tick_n = '0;
				unique case (phase_q)
					PH_ST0: begin sda_n = 1'b0; phase_n = PH_ST1; end
					PH_ST1: begin scl_n = 1'b0; phase_n = PH_ST2; end
					PH_SP0: begin scl_n = 1'b1; phase_n = PH_SP1; end
					PH_SP1: begin sda_n = 1'b1; phase_n = PH_SP2; end
					PH_TX0: begin scl_n = 1'b1; phase_n = PH_TX1; end
					PH_TX1: begin scl_n = 1'b0; phase_n = PH_TX2; end
					PH_TX2: begin
						bit_n = bit_inc;
						if (bit_inc >= BYTE_BITS) begin
							phase_n = PH_IDLE; done_n = 1'b1;
						end else begin
							scl_n = 1'b0; sda_n = shift_q[7];
							shift_n = {shift_q[6:0], 1'b0};
							en_n = 1'b1; phase_n = PH_TX0;
						end
					end
					PH_WA0: begin wait_n = '0; phase_n = PH_WA1; end
					PH_RD0: begin scl_n = 1'b0; phase_n = PH_RD1; end
					PH_RD1: begin scl_n = 1'b1; phase_n = PH_RD2; end
					PH_RD2: begin
						shift_n = rd_shift;
						bit_n = bit_inc;
						if (bit_inc >= BYTE_BITS) begin
							rdata_n = rd_shift; en_n = 1'b1; phase_n = PH_AK0;
						end else begin
							scl_n = 1'b0; phase_n = PH_RD1;
						end
					end
					PH_AK0: begin scl_n = 1'b0; phase_n = PH_AK1; end
					PH_AK1: begin sda_n = !choice_q; phase_n = PH_AK2; end
					PH_AK2: begin scl_n = 1'b1; phase_n = PH_AK3; end
					PH_AK3: begin scl_n = 1'b0; phase_n = PH_AK4; end
					default: begin phase_n = PH_IDLE; done_n = 1'b1; end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			wait_q   <= '0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			en_q     <= 1'b1;
			flags_q  <= 2'b00;
			choice_q <= 1'b0;
			rdata_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			tick_q   <= tick_n;
			bit_q    <= bit_n;
			shift_q  <= shift_n;
			wait_q   <= wait_n;
			scl_q    <= scl_n;
			sda_q    <= sda_n;
			en_q     <= en_n;
			flags_q  <= flags_n;
			choice_q <= choice_n;
			rdata_q  <= rdata_n;
		end
	end

	assign res.scl_out   = scl_n;
	assign res.sda_out   = sda_n;
	assign res.sda_drive = en_n;
	assign res.busy_res  = (phase_n != PH_IDLE);
	assign res.done_res  = done_n;
	assign res.read_data = rdata_n;
	assign res.ack_ok    = flags_n[0];
	assign res.timed_out = flags_n[1];

endmodule

// ----- design/i2c_master_bit_sequencer.sv -----
// Top level of the I2C master bit sequencer: input stage, sequencer, result stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | in        | in_valid/in_ready  | cmd, tx_data, send_ack, sda_in
//  out     | out       | out_valid/out_ready| scl_out, sda_out, sda_drive, busy_res,
//          |           |                    | done_res, read_data, ack_ok, timed_out
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Every input transaction is one line tick and yields exactly one output transaction.
// Throughput is one transaction per cycle while out_ready is high; a transaction passes
// through the input register and then the result register, around the combinational next-state logic.
// Reset returns the lines to released (SCL and SDA high, SDA driven) and the
// configuration to a hold of 10 ticks and an acknowledge limit of 5000 ticks.
// When out_ready is low the result stays in its register, and one more input
// transaction is still taken into the input register before in_ready drops.
module i2c_master_bit_sequencer
	import i2cbs_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Tick input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  tx_data,
	input  logic        send_ack,
	input  logic        sda_in,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_out,
	output logic        sda_out,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_ok,
	output logic        timed_out,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                   valid_s1;
	i2cbs_item_t            item_s1;
	logic                   valid_s2;
	i2cbs_res_t             res_s2;
	i2cbs_res_t             res;
	logic                   advance;
	logic [COUNT_WIDTH-1:0] hold;
	logic [COUNT_WIDTH-1:0] limit;

	// The held tick moves into the sequencer whenever the result register is
	// free or is being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Register writes are always taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, tx_data: tx_data, send_ack: send_ack, sda_in: sda_in};
		end
	end

	i2cbs_cfg #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.hold     (hold),
		.limit    (limit)
	);

	i2cbs_seq #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.hold   (hold),
		.limit  (limit),
		.res    (res)
	);

	// Result register: loaded by each sequencer step, emptied by out_ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign scl_out   = res_s2.scl_out;
	assign sda_out   = res_s2.sda_out;
	assign sda_drive = res_s2.sda_drive;
	assign busy_res  = res_s2.busy_res;
	assign done_res  = res_s2.done_res;
	assign read_data = res_s2.read_data;
	assign ack_ok    = res_s2.ack_ok;
	assign timed_out = res_s2.timed_out;

endmodule

// ----- design/i2cbs_checker.sv -----
// Port-level checks of the I2C master bit sequencer and their bind.
module i2cbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       scl_out,
	input logic       sda_out,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       ack_ok,
	input logic       timed_out
);

	// A command that finishes leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done_res shown while busy_res is high");

	// An acknowledge wait ends either acknowledged or timed out, never both.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ack_ok && timed_out))
		else $error("ack_ok and timed_out both set");

	// Input stalls only when both internal stages are full and the output is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output back-pressure");

	// A held result keeps its line levels and data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl_out) && $stable(sda_out)
			&& $stable(read_data))
		else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.scl_out   (scl_out),
	.sda_out   (sda_out),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.read_data (read_data),
	.ack_ok    (ack_ok),
	.timed_out (timed_out)
);
